// ===== hw/rtl/motion_region_bounding_box_unit_defines.svh =====
// Assertion macros used by the back end of the bounding box unit RTL.
`ifndef MOTION_REGION_BOUNDING_BOX_UNIT_DEFINES_SVH
`define MOTION_REGION_BOUNDING_BOX_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MRBB_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mrbb same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MRBB_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mrbb next-cycle check failed");

`endif

// ===== hw/rtl/mrbb_pkg.sv =====
// Types, constants and padding functions of the bounding box unit.
`default_nettype none
package mrbb_pkg;
   localparam int COORD_BITS = 12;
   localparam int EDGE_BITS = COORD_BITS + 1;
   localparam int VALUE_BITS = 8;
   localparam int COUNT_BITS = 25;
   localparam int CSR_INDEX_BITS = 3;
   localparam int PAD = 10;

   localparam logic [VALUE_BITS-1:0] CHANGE_MARK = 8'd255;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [EDGE_BITS-1:0] RESET_COLUMNS = 13'd640;
   localparam logic [EDGE_BITS-1:0] RESET_ROWS = 13'd480;

   localparam logic [CSR_INDEX_BITS-1:0] REG_REGION_LEFT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REGION_TOP = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REGION_RIGHT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REGION_BOTTOM = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_COLUMNS = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_ROWS = 3'd5;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_COUNT_BITS = 3;
   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_BITS = 1;
   localparam int RSP_COUNT_BITS = 2;

   typedef struct packed {
      logic [EDGE_BITS-1:0] left;
      logic [EDGE_BITS-1:0] top;
      logic [EDGE_BITS-1:0] right;
      logic [EDGE_BITS-1:0] bottom;
   } region_type;

   typedef struct packed {
      logic                  hit;
      logic [COORD_BITS-1:0] column;
      logic [COORD_BITS-1:0] row;
      logic                  last;
   } hit_entry_type;

   typedef struct packed {
      logic          valid;
      hit_entry_type entry;
   } link_type;

   typedef struct packed {
      logic [EDGE_BITS-1:0]  left;
      logic [EDGE_BITS-1:0]  top;
      logic [COORD_BITS-1:0] right;
      logic [COORD_BITS-1:0] bottom;
      logic [COUNT_BITS-1:0] count;
   } box_type;

   function automatic logic [EDGE_BITS-1:0] pad_low(input logic [EDGE_BITS-1:0] edge_val);
      logic [EDGE_BITS-1:0] pad_val;
      pad_val = EDGE_BITS'(PAD);
      return (edge_val > pad_val) ? edge_val - pad_val : edge_val;
   endfunction

   function automatic logic [COORD_BITS-1:0] pad_high(input logic [COORD_BITS-1:0] edge_val,
                                                      input logic [EDGE_BITS-1:0] size);
      logic [EDGE_BITS:0] widened;
      logic [EDGE_BITS:0] sat;
      widened = {2'b00, edge_val} + (EDGE_BITS+1)'(PAD);
      sat = (EDGE_BITS+1)'({COORD_BITS{1'b1}});
      if ((widened + (EDGE_BITS+1)'(1)) < {1'b0, size}) begin
         return (widened > sat) ? {COORD_BITS{1'b1}} : widened[COORD_BITS-1:0];
      end
      return edge_val;
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/mrbb_front.sv =====
// Front end: takes pixel requests, tests them against the region, queues them.
`default_nettype none
module mrbb_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [mrbb_pkg::VALUE_BITS-1:0]     pixel_value,
   input  logic [mrbb_pkg::COORD_BITS-1:0]     pixel_column,
   input  logic [mrbb_pkg::COORD_BITS-1:0]     pixel_row,
   input  logic                                frame_end,
   input  mrbb_pkg::region_type                region,
   output mrbb_pkg::link_type                  link,
   input  logic                                take
);
   import mrbb_pkg::*;

   hit_entry_type                queue_ff [QUEUE_DEPTH];
   hit_entry_type                entry_in;
   logic [QUEUE_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0]  count_ff, count_in;
   logic                         accept;
   logic                         drain;
   logic                         in_region;
   logic [EDGE_BITS-1:0]         column_ext;
   logic [EDGE_BITS-1:0]         row_ext;

   assign column_ext = {1'b0, pixel_column};
   assign row_ext = {1'b0, pixel_row};
   assign in_region = (column_ext >= region.left) && (column_ext < region.right) &&
                      (row_ext >= region.top) && (row_ext < region.bottom);

   assign entry_in.hit = in_region && (pixel_value == CHANGE_MARK);
   assign entry_in.column = pixel_column;
   assign entry_in.row = pixel_row;
   assign entry_in.last = frame_end;

   assign full = (count_ff == QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign accept = push && !full;
   assign link.valid = (count_ff != '0);
   assign link.entry = queue_ff[rd_ptr_ff];
   assign drain = take && link.valid;

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = drain ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (accept && !drain) begin
         count_in = count_ff + QUEUE_COUNT_BITS'(1);
      end else if (drain && !accept) begin
         count_in = count_ff - QUEUE_COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/mrbb_back.sv =====
// Back end: hit trackers, box padding at frame end, result queue.
`default_nettype none
`include "motion_region_bounding_box_unit_defines.svh"
module mrbb_back (
   input  logic                            clock,
   input  logic                            reset,
   input  mrbb_pkg::link_type              link,
   output logic                            take,
   input  logic [mrbb_pkg::EDGE_BITS-1:0]  image_columns,
   input  logic [mrbb_pkg::EDGE_BITS-1:0]  image_rows,
   output logic                            empty,
   input  logic                            pop,
   output mrbb_pkg::box_type               box
);
   import mrbb_pkg::*;

   logic [COUNT_BITS-1:0]      hit_count_ff, hit_count_in, upd_count;
   logic [COORD_BITS-1:0]      min_col_ff, min_col_in, upd_min_col;
   logic [COORD_BITS-1:0]      max_col_ff, max_col_in, upd_max_col;
   logic [COORD_BITS-1:0]      min_row_ff, min_row_in, upd_min_row;
   logic [COORD_BITS-1:0]      max_row_ff, max_row_in, upd_max_row;
   logic                       first;
   logic                       any_hit;
   logic                       finish;
   logic [EDGE_BITS-1:0]       left_raw, top_raw;
   logic [COORD_BITS-1:0]      right_raw, bottom_raw;
   box_type                    box_in;

   box_type                    rsp_queue_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0]    rsp_wr_ff, rsp_wr_in;
   logic [RSP_PTR_BITS-1:0]    rsp_rd_ff, rsp_rd_in;
   logic [RSP_COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic                       rsp_full;
   logic                       rsp_drain;

   assign rsp_full = (rsp_count_ff == RSP_COUNT_BITS'(RSP_DEPTH));
   assign take = !link.entry.last || !rsp_full;
   assign finish = link.valid && take && link.entry.last;
   assign first = (hit_count_ff == '0);

   always_comb begin
      upd_count = hit_count_ff;
      upd_min_col = min_col_ff;
      upd_max_col = max_col_ff;
      upd_min_row = min_row_ff;
      upd_max_row = max_row_ff;
      if (link.valid && take && link.entry.hit) begin
         if (first) begin
            upd_min_col = link.entry.column;
            upd_max_col = link.entry.column;
            upd_min_row = link.entry.row;
            upd_max_row = link.entry.row;
         end else begin
            if (link.entry.column < min_col_ff) upd_min_col = link.entry.column;
            if (link.entry.column > max_col_ff) upd_max_col = link.entry.column;
            if (link.entry.row < min_row_ff) upd_min_row = link.entry.row;
            if (link.entry.row > max_row_ff) upd_max_row = link.entry.row;
         end
         if (hit_count_ff != COUNT_MAX) begin
            upd_count = hit_count_ff + COUNT_BITS'(1);
         end
      end
   end

   // an empty frame takes the image size as its minimum corner before padding
   assign any_hit = (upd_count != '0);
   assign left_raw = (any_hit && ({1'b0, upd_min_col} < image_columns)) ?
                     {1'b0, upd_min_col} : image_columns;
   assign top_raw = (any_hit && ({1'b0, upd_min_row} < image_rows)) ?
                    {1'b0, upd_min_row} : image_rows;
   assign right_raw = any_hit ? upd_max_col : '0;
   assign bottom_raw = any_hit ? upd_max_row : '0;

   assign box_in.left = pad_low(left_raw);
   assign box_in.top = pad_low(top_raw);
   assign box_in.right = pad_high(right_raw, image_columns);
   assign box_in.bottom = pad_high(bottom_raw, image_rows);
   assign box_in.count = upd_count;

   always_comb begin
      hit_count_in = finish ? '0 : upd_count;
      min_col_in = upd_min_col;
      max_col_in = upd_max_col;
      min_row_in = upd_min_row;
      max_row_in = upd_max_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_count_ff <= '0;
      end else begin
         hit_count_ff <= hit_count_in;
      end
   end

   always_ff @(posedge clock) begin
      min_col_ff <= min_col_in;
      max_col_ff <= max_col_in;
      min_row_ff <= min_row_in;
      max_row_ff <= max_row_in;
   end

   assign empty = (rsp_count_ff == '0);
   assign rsp_drain = pop && !empty;
   assign box = rsp_queue_ff[rsp_rd_ff];

   always_comb begin
      rsp_wr_in = finish ? rsp_wr_ff + RSP_PTR_BITS'(1) : rsp_wr_ff;
      rsp_rd_in = rsp_drain ? rsp_rd_ff + RSP_PTR_BITS'(1) : rsp_rd_ff;
      rsp_count_in = rsp_count_ff;
      if (finish && !rsp_drain) begin
         rsp_count_in = rsp_count_ff + RSP_COUNT_BITS'(1);
      end else if (rsp_drain && !finish) begin
         rsp_count_in = rsp_count_ff - RSP_COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_wr_ff <= '0;
         rsp_rd_ff <= '0;
         rsp_count_ff <= '0;
      end else begin
         rsp_wr_ff <= rsp_wr_in;
         rsp_rd_ff <= rsp_rd_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_queue_ff[rsp_wr_ff] <= box_in;
      end
   end

   `MRBB_ASSERT_IMP(a_rsp_no_overflow, clock, reset, finish, !rsp_full)
   `MRBB_ASSERT_IMP(a_rsp_bound, clock, reset, 1'b1,
                    rsp_count_ff <= RSP_COUNT_BITS'(RSP_DEPTH))
   `MRBB_ASSERT_NXT(a_restart, clock, reset, finish, hit_count_ff == '0)
   `MRBB_ASSERT_NXT(a_hit_counted, clock, reset,
                    link.valid && take && link.entry.hit && !link.entry.last,
                    hit_count_ff != '0)
endmodule
`default_nettype wire

// ===== hw/rtl/motion_region_bounding_box_unit.sv =====
// A result passes through the pixel queue and then the result queue before it is on the outputs.
// Throughput: one pixel request per cycle while full is low; a frame-end pixel waits while the result queue is full.
// A 4-entry pixel queue and a 2-entry result queue decouple the two sides.
// Reset (synchronous, active high): queues empty, trackers cleared,
// region registers 0, image size 640 by 480.
`default_nettype none
module motion_region_bounding_box_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    push,
   output logic                                    full,
   input  logic [mrbb_pkg::VALUE_BITS-1:0]         req_pixel_value,
   input  logic [mrbb_pkg::COORD_BITS-1:0]         req_pixel_column,
   input  logic [mrbb_pkg::COORD_BITS-1:0]         req_pixel_row,
   input  logic                                    req_frame_end,
   output logic                                    empty,
   input  logic                                    pop,
   output logic [mrbb_pkg::EDGE_BITS-1:0]          rsp_box_left,
   output logic [mrbb_pkg::EDGE_BITS-1:0]          rsp_box_top,
   output logic [mrbb_pkg::COORD_BITS-1:0]         rsp_box_right,
   output logic [mrbb_pkg::COORD_BITS-1:0]         rsp_box_bottom,
   output logic [mrbb_pkg::COUNT_BITS-1:0]         rsp_change_count,
   input  logic                                    csr_write_enable,
   input  logic [mrbb_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mrbb_pkg::EDGE_BITS-1:0]          csr_data
);
   import mrbb_pkg::*;

   region_type            region_ff, region_in;
   logic [EDGE_BITS-1:0]  columns_ff, columns_in;
   logic [EDGE_BITS-1:0]  rows_ff, rows_in;
   link_type              link;
   logic                  take;
   box_type               box;

   always_comb begin
      region_in = region_ff;
      columns_in = columns_ff;
      rows_in = rows_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_REGION_LEFT: region_in.left = csr_data;
            REG_REGION_TOP: region_in.top = csr_data;
            REG_REGION_RIGHT: region_in.right = csr_data;
            REG_REGION_BOTTOM: region_in.bottom = csr_data;
            REG_IMAGE_COLUMNS: columns_in = csr_data;
            REG_IMAGE_ROWS: rows_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff <= '0;
         columns_ff <= RESET_COLUMNS;
         rows_ff <= RESET_ROWS;
      end else begin
         region_ff <= region_in;
         columns_ff <= columns_in;
         rows_ff <= rows_in;
      end
   end

   mrbb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .pixel_value  (req_pixel_value),
      .pixel_column (req_pixel_column),
      .pixel_row    (req_pixel_row),
      .frame_end    (req_frame_end),
      .region       (region_ff),
      .link         (link),
      .take         (take)
   );

   mrbb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .link          (link),
      .take          (take),
      .image_columns (columns_ff),
      .image_rows    (rows_ff),
      .empty         (empty),
      .pop           (pop),
      .box           (box)
   );

   assign rsp_box_left = box.left;
   assign rsp_box_top = box.top;
   assign rsp_box_right = box.right;
   assign rsp_box_bottom = box.bottom;
   assign rsp_change_count = box.count;
endmodule
`default_nettype wire

// ===== bench/tb_motion_region_bounding_box_unit.sv =====
// Self-checking testbench for the motion region bounding box unit.
module tb_motion_region_bounding_box_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import mrbb_pkg::*;

   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 118;
   localparam int SETTLE_CYCLES = 10;
   localparam int STALL_LIMIT = 5000;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [COORD_BITS-1:0] column;
      logic [COORD_BITS-1:0] row;
      logic                  last;
   } pixel_req_t;

   class box_scoreboard;
      logic [EDGE_BITS-1:0]  roi_left, roi_top, roi_right, roi_bottom;
      logic [EDGE_BITS-1:0]  columns, rows;
      logic [COUNT_BITS-1:0] hits;
      logic [EDGE_BITS-1:0]  lo_col, lo_row;
      logic [COORD_BITS-1:0] hi_col, hi_row;
      box_type               boxes_due[$];
      int                    errors;

      function new();
         roi_left = '0;
         roi_top = '0;
         roi_right = '0;
         roi_bottom = '0;
         columns = RESET_COLUMNS;
         rows = RESET_ROWS;
         errors = 0;
         restart();
      endfunction

      function void restart();
         hits = '0;
         lo_col = columns;
         hi_col = '0;
         lo_row = rows;
         hi_row = '0;
      endfunction

      function void note_write(logic [CSR_INDEX_BITS-1:0] idx, logic [EDGE_BITS-1:0] data);
         case (idx)
            REG_REGION_LEFT: roi_left = data;
            REG_REGION_TOP: roi_top = data;
            REG_REGION_RIGHT: roi_right = data;
            REG_REGION_BOTTOM: roi_bottom = data;
            REG_IMAGE_COLUMNS: columns = data;
            REG_IMAGE_ROWS: rows = data;
            default: ;
         endcase
      endfunction

      function logic [EDGE_BITS-1:0] shrink_low(logic [EDGE_BITS-1:0] e);
         return (e > PAD) ? e - EDGE_BITS'(PAD) : e;
      endfunction

      // widen only while inside the image, clamp to the coordinate range
      function logic [COORD_BITS-1:0] grow_high(logic [COORD_BITS-1:0] e,
                                                logic [EDGE_BITS-1:0] size);
         int unsigned grown;
         grown = e + PAD;
         if (grown + 1 < size)
            return (grown > {COORD_BITS{1'b1}}) ? {COORD_BITS{1'b1}} : COORD_BITS'(grown);
         return e;
      endfunction

      function void note_pixel(pixel_req_t p);
         box_type b;
         if (p.column >= roi_left && p.column < roi_right && p.row >= roi_top &&
             p.row < roi_bottom && p.value == CHANGE_MARK) begin
            if (hits == 0) begin
               lo_col = {1'b0, p.column};
               hi_col = p.column;
               lo_row = {1'b0, p.row};
               hi_row = p.row;
            end else begin
               if (p.column < lo_col) lo_col = {1'b0, p.column};
               if (p.column > hi_col) hi_col = p.column;
               if (p.row < lo_row) lo_row = {1'b0, p.row};
               if (p.row > hi_row) hi_row = p.row;
            end
            if (hits != COUNT_MAX) hits++;
         end
         if (!p.last) return;
         b.left = columns;
         b.top = rows;
         b.right = '0;
         b.bottom = '0;
         if (hits != 0) begin
            if (lo_col < b.left) b.left = lo_col;
            if (lo_row < b.top) b.top = lo_row;
            b.right = hi_col;
            b.bottom = hi_row;
         end
         b.left = shrink_low(b.left);
         b.top = shrink_low(b.top);
         b.right = grow_high(b.right, columns);
         b.bottom = grow_high(b.bottom, rows);
         b.count = hits;
         boxes_due.push_back(b);
         restart();
      endfunction

      function void check_box(box_type got);
         box_type want;
         if (boxes_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected box: l=%0d t=%0d r=%0d b=%0d n=%0d",
                        got.left, got.top, got.right, got.bottom, got.count);
            return;
         end
         want = boxes_due.pop_front();
         if (got.left !== want.left || got.top !== want.top || got.right !== want.right ||
             got.bottom !== want.bottom || got.count !== want.count) begin
            errors++;
            if (errors <= 10)
               $display({"box mismatch at %0t: expected l=%0d t=%0d r=%0d b=%0d n=%0d, ",
                         "got l=%0d t=%0d r=%0d b=%0d n=%0d"},
                        $realtime, want.left, want.top, want.right, want.bottom, want.count,
                        got.left, got.top, got.right, got.bottom, got.count);
         end
      endfunction

      function int pending();
         return boxes_due.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      push = 1'b0;
   logic                      full;
   logic [VALUE_BITS-1:0]     req_pixel_value = '0;
   logic [COORD_BITS-1:0]     req_pixel_column = '0;
   logic [COORD_BITS-1:0]     req_pixel_row = '0;
   logic                      req_frame_end = 1'b0;
   logic                      empty;
   logic                      pop = 1'b0;
   logic [EDGE_BITS-1:0]      rsp_box_left;
   logic [EDGE_BITS-1:0]      rsp_box_top;
   logic [COORD_BITS-1:0]     rsp_box_right;
   logic [COORD_BITS-1:0]     rsp_box_bottom;
   logic [COUNT_BITS-1:0]     rsp_change_count;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [EDGE_BITS-1:0]      csr_data = '0;

   int            send_idle_pct = 0;
   int            stall_pct = 0;
   int            stalled = 0;
   box_scoreboard sb = new();

   motion_region_bounding_box_unit DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_pixel_value(req_pixel_value),
      .req_pixel_column(req_pixel_column),
      .req_pixel_row(req_pixel_row),
      .req_frame_end(req_frame_end),
      .empty(empty),
      .pop(pop),
      .rsp_box_left(rsp_box_left),
      .rsp_box_top(rsp_box_top),
      .rsp_box_right(rsp_box_right),
      .rsp_box_bottom(rsp_box_bottom),
      .rsp_change_count(rsp_change_count),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial forever #1 clock = ~clock;

   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty)
         sb.check_box({rsp_box_left, rsp_box_top, rsp_box_right, rsp_box_bottom,
                       rsp_change_count});
   end

   always @(posedge clock) begin
      if (reset || csr_write_enable || (push && !full) || (pop && !empty)) begin
         stalled <= 0;
      end else begin
         stalled <= stalled + 1;
         if (stalled >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic send_pixel(logic [VALUE_BITS-1:0] v, logic [COORD_BITS-1:0] c,
                             logic [COORD_BITS-1:0] r, logic fe);
      pixel_req_t p;
      p = '{v, c, r, fe};
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_pixel_value <= v;
      req_pixel_column <= c;
      req_pixel_row <= r;
      req_frame_end <= fe;
      do @(posedge clock); while (full);
      sb.note_pixel(p);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, int data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= EDGE_BITS'(data);
      sb.note_write(idx, EDGE_BITS'(data));
      @(negedge clock);
   endtask

   task automatic program_regs(int left, int top, int right, int bottom, int cols, int rows);
      write_reg(REG_REGION_LEFT, left);
      write_reg(REG_REGION_TOP, top);
      write_reg(REG_REGION_RIGHT, right);
      write_reg(REG_REGION_BOTTOM, bottom);
      write_reg(REG_IMAGE_COLUMNS, cols);
      write_reg(REG_IMAGE_ROWS, rows);
      csr_write_enable <= 1'b0;
   endtask

   // pixels still queued may belong to an unfinished frame, so keep draining for SETTLE_CYCLES more
   task automatic settle();
      push <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [COORD_BITS-1:0] pick_coord(int lo_b, int hi_b);
      int lo, hi;
      lo = lo_b - 3;
      if (lo < 0) lo = 0;
      hi = hi_b + 2;
      if (hi > 4095) hi = 4095;
      if (lo > hi || $urandom_range(9) < 3) return COORD_BITS'($urandom);
      return COORD_BITS'($urandom_range(hi, lo));
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) return CHANGE_MARK;
      if (roll < 60) return CHANGE_MARK - 1'b1;
      if (roll < 70) return '0;
      return VALUE_BITS'($urandom);
   endfunction

   task automatic choose_setting(int ph);
      int l, t, r, b;
      case (ph % 8)
         0: program_regs(0, 0, 4096, 4096, 640, 480);
         1: begin
            l = $urandom_range(600);
            t = $urandom_range(440);
            program_regs(l, t, l + $urandom_range(60, 1), t + $urandom_range(60, 1), 640, 480);
         end
         2: program_regs(0, 0, 4096, 4096, 4096, 4096);
         3: program_regs(0, 0, $urandom_range(8), $urandom_range(8), 1, 1);
         4: begin
            // empty or inverted region
            l = $urandom_range(4096);
            t = $urandom_range(4096);
            program_regs(l, t, $urandom_range(l), $urandom_range(4096),
                         $urandom_range(4096, 1), $urandom_range(4096, 1));
         end
         default: begin
            l = $urandom_range(4000);
            t = $urandom_range(4000);
            r = l + $urandom_range(96, 1);
            b = t + $urandom_range(96, 1);
            if (r > 4096) r = 4096;
            if (b > 4096) b = 4096;
            program_regs(l, t, r, b, $urandom_range(4096, 1), $urandom_range(4096, 1));
         end
      endcase
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset region is empty: no hits, box from image size
      send_pixel(CHANGE_MARK, 12'd0, 12'd0, 1'b1);
      settle();

      program_regs(0, 0, 4096, 4096, 640, 480);
      send_pixel(CHANGE_MARK, 12'd11, 12'd10, 1'b0);
      send_pixel(8'd254, 12'd500, 12'd500, 1'b0);
      send_pixel(8'd0, 12'd3, 12'd3, 1'b0);
      send_pixel(CHANGE_MARK, 12'd628, 12'd479, 1'b1);
      send_pixel(CHANGE_MARK, 12'd4095, 12'd4095, 1'b0);
      send_pixel(CHANGE_MARK, 12'd0, 12'd0, 1'b1);
      send_pixel(CHANGE_MARK, 12'd629, 12'd5, 1'b1);
      settle();

      // inverted region, zero image size
      program_regs(100, 0, 50, 4096, 0, 0);
      send_pixel(CHANGE_MARK, 12'd70, 12'd70, 1'b1);
      send_pixel(CHANGE_MARK, 12'd100, 12'd10, 1'b1);
      settle();

      // oversized image: right and bottom padding clamps
      program_regs(1, 1, 4096, 4096, 8191, 8191);
      send_pixel(CHANGE_MARK, 12'd0, 12'd5, 1'b0);
      send_pixel(CHANGE_MARK, 12'd4095, 12'd4095, 1'b0);
      send_pixel(CHANGE_MARK, 12'd1, 12'd1, 1'b1);
      settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         choose_setting(ph);
         case (ph % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 49; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 49; end
            default: begin send_idle_pct = 18; stall_pct = 18; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_pixel(pick_value(), pick_coord(sb.roi_left, sb.roi_right),
                       pick_coord(sb.roi_top, sb.roi_bottom), $urandom_range(7) == 0);
         settle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
